// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/magocc_pkg.sv =====
// Package for the magnet occupancy detector: widths, register map, reset values.
package magocc_pkg;

    localparam int unsigned MAG_W   = 16;
    localparam int unsigned TOL_W   = 10;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned THR_W   = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(10);
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(5);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(250);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETTLE_TOL  = 2'd0,
        CFG_SETTLE_CNT  = 2'd1,
        CFG_PRESENCE_TH = 2'd2
    } t_cfg_idx;

    // Exact |a - b| of two signed samples; always fits MAG_W unsigned bits.
    function automatic logic [MAG_W-1:0] abs_diff(input logic signed [MAG_W-1:0] a,
                                                  input logic signed [MAG_W-1:0] b);
        logic signed [MAG_W:0] d;
        logic        [MAG_W:0] m;
        d = {a[MAG_W-1], a} - {b[MAG_W-1], b};
        m = d[MAG_W] ? (~d + 1'b1) : d;
        return m[MAG_W-1:0];
    endfunction

endpackage

// ===== src/magnet_occupancy_detector_core.sv =====
// Top level: magnetometer baseline calibration and magnet presence / occupancy tracking.
//
// Input channel: i_in_valid / o_in_ready carry one 3-axis sample (i_mag_x/y/z).
// Output channel: o_out_valid / i_out_ready carry one result per sample:
//   o_calibrated, o_magnet_present, o_room_occupied (all zero while calibrating).
// Config port: i_cfg_we writes i_cfg_wdata into register i_cfg_idx
//   (0 settle tolerance, 1 settle sample count, 2 presence threshold);
//   other indexes are ignored. Write only while the block is idle.
// A sample passes through the input register and then the result register.
// Throughput: one sample per cycle while the receiver takes every result; the
//   baseline/count/flag state is updated in place as each sample leaves the input register, so the compare and
//   update logic between the two registers sets the pace.
// The input register can still take one sample while a result waits; when the
//   receiver stalls both registers fill and o_in_ready drops until it drains.
// Reset (synchronous, active low) empties both registers, restores the
//   register defaults and restarts calibration from scratch.
`include "assert_macros.svh"

module magnet_occupancy_detector_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [magocc_pkg::MAG_W-1:0]   i_mag_x,
    input  logic signed [magocc_pkg::MAG_W-1:0]   i_mag_y,
    input  logic signed [magocc_pkg::MAG_W-1:0]   i_mag_z,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_calibrated,
    output logic                                  o_magnet_present,
    output logic                                  o_room_occupied,
    input  logic                                  i_cfg_we,
    input  logic [magocc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [magocc_pkg::CFG_W-1:0]          i_cfg_wdata
);

    // config registers
    logic [magocc_pkg::TOL_W-1:0] r_tol;
    logic [magocc_pkg::CNT_W-1:0] r_settle;
    logic [magocc_pkg::THR_W-1:0] r_thr;

    // input register
    logic                                r_in_valid;
    logic signed [magocc_pkg::MAG_W-1:0] r_x, r_y, r_z;

    // detector state
    logic signed [magocc_pkg::MAG_W-1:0] r_base_x, r_base_y, r_base_z;
    logic signed [magocc_pkg::MAG_W-1:0] n_base_x, n_base_y, n_base_z;
    logic                                r_have_base, n_have_base;
    logic [magocc_pkg::CNT_W-1:0]        r_stable_cnt, n_stable_cnt;
    logic                                r_is_cal, n_is_cal;
    logic                                r_prev_present, n_prev_present;
    logic                                r_occupied, n_occupied;

    // result register
    logic r_out_valid;
    logic r_calibrated, n_calibrated;
    logic r_present, n_present;
    logic r_room_occ, n_room_occ;

    logic advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= magocc_pkg::TOL_RESET;
            r_settle <= magocc_pkg::CNT_RESET;
            r_thr    <= magocc_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            unique case (magocc_pkg::t_cfg_idx'(i_cfg_idx))
                magocc_pkg::CFG_SETTLE_TOL:  r_tol    <= i_cfg_wdata[magocc_pkg::TOL_W-1:0];
                magocc_pkg::CFG_SETTLE_CNT:  r_settle <= i_cfg_wdata[magocc_pkg::CNT_W-1:0];
                magocc_pkg::CFG_PRESENCE_TH: r_thr    <= i_cfg_wdata[magocc_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // per-sample update
    always_comb begin
        logic [magocc_pkg::MAG_W-1:0] dx, dy, dz;
        logic [magocc_pkg::MAG_W-1:0] tol_ext;
        logic [magocc_pkg::CNT_W-1:0] cnt_inc;
        logic                         stable;
        logic                         present;

        dx      = magocc_pkg::abs_diff(r_base_x, r_x);
        dy      = magocc_pkg::abs_diff(r_base_y, r_y);
        dz      = magocc_pkg::abs_diff(r_base_z, r_z);
        tol_ext = {{(magocc_pkg::MAG_W - magocc_pkg::TOL_W){1'b0}}, r_tol};
        stable  = (dx < tol_ext) && (dy < tol_ext) && (dz < tol_ext);
        present = (dx > r_thr) || (dy > r_thr) || (dz > r_thr);
        cnt_inc = r_stable_cnt + 1'b1;

        n_base_x       = r_base_x;
        n_base_y       = r_base_y;
        n_base_z       = r_base_z;
        n_have_base    = r_have_base;
        n_stable_cnt   = r_stable_cnt;
        n_is_cal       = r_is_cal;
        n_prev_present = r_prev_present;
        n_occupied     = r_occupied;
        n_calibrated   = 1'b0;
        n_present      = 1'b0;
        n_room_occ     = 1'b0;

        if (!r_is_cal) begin
            if (!r_have_base || !stable) begin
                // take (or retake) the baseline
                n_base_x     = r_x;
                n_base_y     = r_y;
                n_base_z     = r_z;
                n_have_base  = 1'b1;
                n_stable_cnt = '0;
            end else begin
                n_stable_cnt = cnt_inc;
                n_is_cal     = (cnt_inc >= r_settle);
            end
        end else begin
            // toggle on the rising edge of presence
            n_occupied     = r_occupied ^ (present && !r_prev_present);
            n_prev_present = present;
            n_calibrated   = 1'b1;
            n_present      = present;
            n_room_occ     = n_occupied;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_have_base    <= 1'b0;
            r_stable_cnt   <= '0;
            r_is_cal       <= 1'b0;
            r_prev_present <= 1'b0;
            r_occupied     <= 1'b0;
            r_base_x       <= '0;
            r_base_y       <= '0;
            r_base_z       <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid    <= 1'b1;
                r_base_x       <= n_base_x;
                r_base_y       <= n_base_y;
                r_base_z       <= n_base_z;
                r_have_base    <= n_have_base;
                r_stable_cnt   <= n_stable_cnt;
                r_is_cal       <= n_is_cal;
                r_prev_present <= n_prev_present;
                r_occupied     <= n_occupied;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_x <= i_mag_x;
            r_y <= i_mag_y;
            r_z <= i_mag_z;
        end
        if (advance) begin
            r_calibrated <= n_calibrated;
            r_present    <= n_present;
            r_room_occ   <= n_room_occ;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_calibrated     = r_calibrated;
    assign o_magnet_present = r_present;
    assign o_room_occupied  = r_room_occ;

    `ASSERT_IMPLY(a_uncal_quiet, i_clk, i_rst_n, o_out_valid && !o_calibrated, !o_magnet_present && !o_room_occupied)
    `ASSERT_NEXT(a_cal_sticky, i_clk, i_rst_n, r_is_cal, r_is_cal)
    `ASSERT_IMPLY(a_cal_result_state, i_clk, i_rst_n, o_out_valid && o_calibrated, r_is_cal && r_have_base)
    `ASSERT_IMPLY(a_full_stall, i_clk, i_rst_n, r_in_valid && r_out_valid && !i_out_ready, !o_in_ready)

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the magnet occupancy detector core.
module tb;

    typedef logic signed [magocc_pkg::MAG_W-1:0] t_sample;

    typedef struct packed {
        logic calibrated;
        logic present;
        logic occupied;
    } t_occ_result;

    // not mapped to any register
    localparam logic [magocc_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
    localparam int AXIS_MAX = 32767;
    localparam int AXIS_MIN = -32768;
    localparam t_sample S_MAX = t_sample'(AXIS_MAX);
    localparam t_sample S_MIN = t_sample'(AXIS_MIN);
    localparam int IDLE_PCT = 22;
    localparam int MAX_REPORTS = 40;

    class occupancy_scoreboard;
        logic [magocc_pkg::TOL_W-1:0] tol;
        logic [magocc_pkg::CNT_W-1:0] need;
        logic [magocc_pkg::THR_W-1:0] thr;
        t_sample bx, by, bz;
        logic [magocc_pkg::CNT_W-1:0] stable_cnt;
        bit have_base, calibrated, last_present, occupied;
        t_occ_result expected_q[$];
        int errors, n_checked, n_cal_items, n_rises;

        function new();
            tol = magocc_pkg::TOL_RESET;
            need = magocc_pkg::CNT_RESET;
            thr = magocc_pkg::THR_RESET;
            bx = '0;
            by = '0;
            bz = '0;
            stable_cnt = '0;
        endfunction

        function void write_reg(logic [magocc_pkg::CFG_IDX_W-1:0] idx,
                                logic [magocc_pkg::CFG_W-1:0] data);
            case (idx)
                magocc_pkg::CFG_SETTLE_TOL:  tol  = data[magocc_pkg::TOL_W-1:0];
                magocc_pkg::CFG_SETTLE_CNT:  need = data[magocc_pkg::CNT_W-1:0];
                magocc_pkg::CFG_PRESENCE_TH: thr  = data[magocc_pkg::THR_W-1:0];
                default: ;
            endcase
        endfunction

        static function int unsigned axis_dist(t_sample a, t_sample b);
            int d;
            d = int'(a) - int'(b);
            return (d < 0) ? -d : d;
        endfunction

        // Called once per accepted sample; advances the expected state.
        function void note_sample(t_sample x, t_sample y, t_sample z);
            t_occ_result r;
            bit present;
            r = '0;
            if (!calibrated) begin
                n_cal_items++;
                if (!have_base) begin
                    bx = x;
                    by = y;
                    bz = z;
                    have_base = 1'b1;
                    stable_cnt = '0;
                end else if (axis_dist(bx, x) < tol && axis_dist(by, y) < tol &&
                             axis_dist(bz, z) < tol) begin
                    stable_cnt = stable_cnt + 1'b1;
                    if (stable_cnt >= need) calibrated = 1'b1;
                end else begin
                    stable_cnt = '0;
                    bx = x;
                    by = y;
                    bz = z;
                end
            end else begin
                present = axis_dist(bx, x) > thr || axis_dist(by, y) > thr ||
                          axis_dist(bz, z) > thr;
                if (present && !last_present) begin
                    occupied = !occupied;
                    n_rises++;
                end
                last_present = present;
                r.calibrated = 1'b1;
                r.present = present;
                r.occupied = occupied;
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(logic cal, logic pres, logic occ);
            t_occ_result want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with nothing expected: cal=%b present=%b occupied=%b",
                             $time, cal, pres, occ);
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (want.calibrated !== cal || want.present !== pres || want.occupied !== occ) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: item %0d expected cal=%b present=%b occupied=%b, actual %b %b %b",
                             $time, n_checked, want.calibrated, want.present, want.occupied,
                             cal, pres, occ);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_sample i_mag_x, i_mag_y, i_mag_z;
    logic o_out_valid;
    logic i_out_ready;
    logic o_calibrated, o_magnet_present, o_room_occupied;
    logic i_cfg_we;
    logic [magocc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [magocc_pkg::CFG_W-1:0] i_cfg_wdata;

    occupancy_scoreboard sb;
    bit steady = 1'b0;     // no idling on either side while set
    bit magnet_on = 1'b0;

    magnet_occupancy_detector_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mag_x          (i_mag_x),
        .i_mag_y          (i_mag_y),
        .i_mag_z          (i_mag_z),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_calibrated     (o_calibrated),
        .o_magnet_present (o_magnet_present),
        .o_room_occupied  (o_room_occupied),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver back-pressure.
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_calibrated, o_magnet_present, o_room_occupied);
        end
    end

    function automatic t_sample sat16(int v);
        if (v > AXIS_MAX) return S_MAX;
        if (v < AXIS_MIN) return S_MIN;
        return t_sample'(v);
    endfunction

    function automatic t_sample jitter(t_sample b, int span);
        return sat16(int'(b) + int'($urandom_range(2 * span)) - span);
    endfunction

    task automatic feed_sample(input t_sample x, input t_sample y, input t_sample z);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_mag_x <= x;
        i_mag_y <= y;
        i_mag_z <= z;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample(x, y, z);
    endtask

    task automatic cfg_write(input logic [magocc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [magocc_pkg::CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Mostly small wobble around the baseline, with occasional jumps.
    task automatic feed_cal_noise(input int span);
        if ($urandom_range(3) == 0)
            feed_sample(t_sample'($urandom), t_sample'($urandom), t_sample'($urandom));
        else
            feed_sample(jitter(sb.bx, span), jitter(sb.by, span), jitter(sb.bz, span));
    endtask

    // A magnet that comes and goes, plus threshold-edge and fully random samples.
    task automatic feed_presence_sample();
        t_sample base [3];
        t_sample v [3];
        int a, pick, reach;
        base[0] = sb.bx;
        base[1] = sb.by;
        base[2] = sb.bz;
        reach = int'(sb.thr);
        if ($urandom_range(7) == 0) magnet_on = !magnet_on;
        case ($urandom_range(9))
            0: begin
                for (a = 0; a < 3; a++) v[a] = t_sample'($urandom);
            end
            1: begin
                for (a = 0; a < 3; a++)
                    v[a] = sat16(int'(base[a]) + ($urandom_range(1) ? 1 : -1) *
                                 (reach + int'($urandom_range(1))));
            end
            default: begin
                for (a = 0; a < 3; a++) v[a] = jitter(base[a], reach / 2);
                if (magnet_on) begin
                    pick = $urandom_range(2);
                    v[pick] = sat16(int'(base[pick]) + ($urandom_range(1) ? 1 : -1) *
                                    (reach + 1 + int'($urandom_range(reach / 4))));
                end
            end
        endcase
        feed_sample(v[0], v[1], v[2]);
    endtask

    initial begin
        logic [magocc_pkg::CFG_W-1:0] wd;
        int ph;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_mag_x <= '0;
        i_mag_y <= '0;
        i_mag_z <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= magocc_pkg::CFG_SETTLE_TOL;
        i_cfg_wdata <= '0;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero tolerance: every sample replaces the baseline.
        cfg_write(CFG_SPARE_IDX, 16'h0000);
        cfg_write(magocc_pkg::CFG_SETTLE_TOL, 16'hFC00);
        feed_sample(S_MIN, S_MIN, S_MIN);
        feed_sample(S_MIN, S_MIN, S_MIN);
        feed_sample(S_MAX, S_MAX, S_MAX);
        feed_sample(S_MAX, S_MIN, '0);
        drain();

        // Widest tolerance, longest settle count; probe the tolerance edge.
        cfg_write(magocc_pkg::CFG_SETTLE_TOL, 16'hFFFF);
        cfg_write(magocc_pkg::CFG_SETTLE_CNT, 16'hFFFF);
        feed_sample(t_sample'(31745), t_sample'(-31746), t_sample'(1022));
        feed_sample(t_sample'(31745), t_sample'(-31745), '0);
        feed_sample(t_sample'(31745), t_sample'(-31745), '0);
        feed_sample(S_MAX, t_sample'(-32767), t_sample'(-1022));

        for (ph = 0; ph < 3; ph++) begin
            drain();
            wd = magocc_pkg::CFG_W'($urandom);
            wd[magocc_pkg::TOL_W-1:0] = (ph == 0) ? magocc_pkg::TOL_W'(1) :
                ($urandom_range(1) ? magocc_pkg::TOL_W'($urandom_range(1, 8)) :
                                     magocc_pkg::TOL_W'($urandom_range(1, 1023)));
            cfg_write(magocc_pkg::CFG_SETTLE_TOL, wd);
            wd = magocc_pkg::CFG_W'($urandom);
            wd[magocc_pkg::CNT_W-1:0] = magocc_pkg::CNT_W'(15);
            cfg_write(magocc_pkg::CFG_SETTLE_CNT, wd);
            repeat (50) feed_cal_noise(int'(sb.tol) + 1);
        end

        // A settle count of zero ends calibration on the next stable sample.
        drain();
        cfg_write(magocc_pkg::CFG_SETTLE_CNT, 16'hABC0);
        while (!sb.calibrated) feed_sample(sb.bx, sb.by, sb.bz);

        drain();
        cfg_write(magocc_pkg::CFG_PRESENCE_TH, 16'h0000);
        feed_sample(sb.bx, sb.by, sb.bz);
        feed_sample(sat16(int'(sb.bx) + 1), sb.by, sb.bz);
        feed_sample(sb.bx, sb.by, sb.bz);
        feed_sample(sb.bx, sb.by, sat16(int'(sb.bz) - 1));
        drain();
        cfg_write(magocc_pkg::CFG_PRESENCE_TH, 16'hFFFF);
        feed_sample(S_MIN, S_MIN, S_MIN);
        feed_sample(S_MAX, S_MAX, S_MAX);
        drain();
        cfg_write(magocc_pkg::CFG_PRESENCE_TH, 16'd300);
        feed_sample(sb.bx, sat16(int'(sb.by) + 300), sb.bz);
        feed_sample(sb.bx, sat16(int'(sb.by) + 301), sb.bz);
        feed_sample(sb.bx, sat16(int'(sb.by) - 301), sb.bz);
        feed_sample(sb.bx, sb.by, sb.bz);

        for (ph = 0; ph < 10; ph++) begin
            drain();
            case (ph)
                0: wd = '0;
                1: wd = '1;
                default: begin
                    if ($urandom_range(3) == 0) wd = magocc_pkg::CFG_W'($urandom_range(8));
                    else if ($urandom_range(3) == 0) wd = magocc_pkg::CFG_W'($urandom);
                    else wd = magocc_pkg::CFG_W'($urandom_range(3000));
                end
            endcase
            cfg_write(magocc_pkg::CFG_PRESENCE_TH, wd);
            // calibration is over; these must change nothing
            cfg_write(magocc_pkg::CFG_SETTLE_TOL, magocc_pkg::CFG_W'($urandom));
            cfg_write(magocc_pkg::CFG_SETTLE_CNT, magocc_pkg::CFG_W'($urandom));
            if (ph == 5) cfg_write(CFG_SPARE_IDX, magocc_pkg::CFG_W'($urandom));
            steady = (ph == 4);
            repeat (160) feed_presence_sample();
        end
        steady = 1'b0;

        drain();
        $display("checked %0d results: %0d calibration samples, %0d presence onsets",
                 sb.n_checked, sb.n_cal_items, sb.n_rises);
        $display("threshold runs included 0 and full scale; %0d errors", sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
